FILE: hdl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define AZS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked on every edge, reset included
`define AZS_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: hdl/azs_pkg.sv
`timescale 1ns / 1ps
package azs_pkg;

  localparam int LINE_W     = 4;
  localparam int SAMPLE_W   = 12;
  localparam int THR_W      = 12;
  localparam int CNT_W      = 3;
  localparam int CLS_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int NUM_LINES_DEF = 16;

  localparam logic [THR_W-1:0] UNUSED_THR_RST  = 12'd3200;
  localparam logic [THR_W-1:0] ALARM_THR_RST   = 12'd1000;
  localparam logic [CNT_W-1:0] CONFIRM_CNT_RST = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_CNT = 2'd2;

  typedef enum logic [CLS_W-1:0] {
    CLS_ALARM  = 2'd0,
    CLS_UNUSED = 2'd1,
    CLS_NORMAL = 2'd2
  } cls_t;

  typedef struct packed {
    logic              fire;
    logic [LINE_W-1:0] line;
    cls_t              cls;
  } line_req_t;

  typedef struct packed {
    cls_t held;
    logic panel;
  } line_rsp_t;

endpackage

FILE: hdl/azs_classify.sv
`timescale 1ns / 1ps
module azs_classify (
  input  logic [azs_pkg::SAMPLE_W-1:0] sample,
  input  logic [azs_pkg::THR_W-1:0]    unused_thr,
  input  logic [azs_pkg::THR_W-1:0]    alarm_thr,
  output azs_pkg::cls_t                cls
);

  always_comb begin
    if (sample > unused_thr) begin
      cls = azs_pkg::CLS_UNUSED;
    end else if (sample < alarm_thr) begin
      cls = azs_pkg::CLS_ALARM;
    end else begin
      cls = azs_pkg::CLS_NORMAL;
    end
  end

endmodule

FILE: hdl/azs_line_state.sv
`timescale 1ns / 1ps
module azs_line_state #(
  parameter int NUM_LINES = azs_pkg::NUM_LINES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  azs_pkg::line_req_t        req,
  input  logic [azs_pkg::CNT_W-1:0] confirm_cnt,
  output azs_pkg::line_rsp_t        rsp
);

  localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int CMP_W = ((IDX_W > azs_pkg::LINE_W) ? IDX_W : azs_pkg::LINE_W) + 1;

  logic                      in_run_r [NUM_LINES];
  logic [azs_pkg::CNT_W-1:0] cnt_r    [NUM_LINES];
  azs_pkg::cls_t             held_r   [NUM_LINES];
  logic                      scan_r;

  logic [CMP_W-1:0]          line_ext;
  logic                      in_range;
  logic [IDX_W-1:0]          idx;
  logic                      run_sel;
  logic [azs_pkg::CNT_W-1:0] cnt_sel;
  azs_pkg::cls_t             held_sel;
  logic [azs_pkg::CNT_W:0]   cnt_inc;
  logic                      run_nxt;
  logic [azs_pkg::CNT_W-1:0] cnt_nxt;
  azs_pkg::cls_t             held_nxt;
  logic                      scan_nxt;

  assign line_ext = CMP_W'(req.line);
  assign in_range = line_ext < CMP_W'(NUM_LINES);
  assign idx      = in_range ? line_ext[IDX_W-1:0] : '0;

  always_comb begin
    run_sel  = in_run_r[idx];
    cnt_sel  = cnt_r[idx];
    held_sel = held_r[idx];
    cnt_inc  = {1'b0, cnt_sel} + 1'b1;
    run_nxt  = run_sel;
    cnt_nxt  = cnt_sel;
    held_nxt = held_sel;
    scan_nxt = scan_r;
    if (req.fire && in_range) begin
      if (req.line == '0) begin
        scan_nxt = 1'b0;
      end
      case (req.cls)
        azs_pkg::CLS_UNUSED: begin
          held_nxt = azs_pkg::CLS_UNUSED;
        end
        azs_pkg::CLS_ALARM: begin
          if (!run_sel) begin
            run_nxt = 1'b1;
            cnt_nxt = azs_pkg::CNT_W'(1);
          end else if (cnt_inc >= {1'b0, confirm_cnt}) begin
            cnt_nxt  = confirm_cnt;
            held_nxt = azs_pkg::CLS_ALARM;
            scan_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_inc[azs_pkg::CNT_W-1:0];
          end
        end
        default: begin
          run_nxt  = 1'b0;
          cnt_nxt  = '0;
          held_nxt = azs_pkg::CLS_NORMAL;
        end
      endcase
    end
    rsp.held  = in_range ? held_nxt : azs_pkg::CLS_NORMAL;
    rsp.panel = scan_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        in_run_r[i] <= 1'b0;
        cnt_r[i]    <= '0;
        held_r[i]   <= azs_pkg::CLS_NORMAL;
      end
      scan_r <= 1'b0;
    end else if (req.fire && in_range) begin
      in_run_r[idx] <= run_nxt;
      cnt_r[idx]    <= cnt_nxt;
      held_r[idx]   <= held_nxt;
      scan_r        <= scan_nxt;
    end
  end

endmodule

FILE: hdl/alarm_zone_supervisor_core.sv
`timescale 1ns / 1ps
// channel  direction  handshake             payload
// in_      to core    in_valid / in_stall   in_line_index, in_sample
// out_     from core  out_valid / out_stall out_line_class, out_held_class, out_panel_alarm
// cfg_     to core    cfg_wr_en             cfg_index, cfg_wdata
//
// an accepted request passes the input register, then the result register around the line update
// one request per cycle sustained while out_stall stays low
// synchronous active-low reset clears line state, config to defaults, both stages empty
// a stalled result holds the result register; the input register fills, then in_stall rises
module alarm_zone_supervisor_core #(
  parameter int NUM_LINES = azs_pkg::NUM_LINES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [azs_pkg::LINE_W-1:0]     in_line_index,
  input  logic [azs_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [azs_pkg::CLS_W-1:0]      out_line_class,
  output logic [azs_pkg::CLS_W-1:0]      out_held_class,
  output logic                           out_panel_alarm,
  input  logic                           cfg_wr_en,
  input  logic [azs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [azs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [azs_pkg::THR_W-1:0]    unused_thr_r;
  logic [azs_pkg::THR_W-1:0]    alarm_thr_r;
  logic [azs_pkg::CNT_W-1:0]    confirm_cnt_r;

  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  logic [azs_pkg::LINE_W-1:0]   s1_line_r;
  logic [azs_pkg::SAMPLE_W-1:0] s1_sample_r;

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  azs_pkg::cls_t                out_line_class_r;
  azs_pkg::cls_t                out_held_class_r;
  logic                         out_panel_alarm_r;

  logic                         advance;
  logic                         in_acc;
  logic                         fire;
  azs_pkg::cls_t                cls;
  azs_pkg::line_req_t           req;
  azs_pkg::line_rsp_t           rsp;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unused_thr_r  <= azs_pkg::UNUSED_THR_RST;
      alarm_thr_r   <= azs_pkg::ALARM_THR_RST;
      confirm_cnt_r <= azs_pkg::CONFIRM_CNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        azs_pkg::CFG_UNUSED_THR:  unused_thr_r  <= cfg_wdata[azs_pkg::THR_W-1:0];
        azs_pkg::CFG_ALARM_THR:   alarm_thr_r   <= cfg_wdata[azs_pkg::THR_W-1:0];
        azs_pkg::CFG_CONFIRM_CNT: confirm_cnt_r <= cfg_wdata[azs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance       = !out_valid_r || !out_stall;
  assign in_stall      = s1_valid_r && !advance;
  assign in_acc        = in_valid && !in_stall;
  assign fire          = s1_valid_r && advance;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !advance);
  assign out_valid_nxt = fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_line_r   <= in_line_index;
      s1_sample_r <= in_sample;
    end
  end

  azs_classify u_classify (
    .sample     (s1_sample_r),
    .unused_thr (unused_thr_r),
    .alarm_thr  (alarm_thr_r),
    .cls        (cls)
  );

  assign req.fire = fire;
  assign req.line = s1_line_r;
  assign req.cls  = cls;

  azs_line_state #(
    .NUM_LINES (NUM_LINES)
  ) u_line_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .confirm_cnt (confirm_cnt_r),
    .rsp         (rsp)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      out_line_class_r  <= cls;
      out_held_class_r  <= rsp.held;
      out_panel_alarm_r <= rsp.panel;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_class  = out_line_class_r;
  assign out_held_class  = out_held_class_r;
  assign out_panel_alarm = out_panel_alarm_r;

endmodule

FILE: hdl/azs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module azs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [azs_pkg::LINE_W-1:0]   in_line_index,
  input logic [azs_pkg::SAMPLE_W-1:0] in_sample,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [azs_pkg::CLS_W-1:0]    out_line_class,
  input logic [azs_pkg::CLS_W-1:0]    out_held_class,
  input logic                         out_panel_alarm
);

  logic [azs_pkg::LINE_W+azs_pkg::SAMPLE_W-1:0] in_req;
  logic [2*azs_pkg::CLS_W:0]                    out_rsp;
  logic                                         cls_alarm;
  logic                                         cls_normal;
  logic                                         held_alarm;
  logic                                         held_normal;

  assign in_req      = {in_line_index, in_sample};
  assign out_rsp     = {out_line_class, out_held_class, out_panel_alarm};
  assign cls_alarm   = out_line_class == azs_pkg::CLS_ALARM;
  assign cls_normal  = out_line_class == azs_pkg::CLS_NORMAL;
  assign held_alarm  = out_held_class == azs_pkg::CLS_ALARM;
  assign held_normal = out_held_class == azs_pkg::CLS_NORMAL;

  // result channel empties on reset
  `AZS_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid)

  // a stalled request stays put
  `AZS_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(in_req))

  // a stalled result stays put
  `AZS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_rsp))

  // confirmed alarm only shows with an alarm reading
  `AZS_ASSERT(a_held_alarm, out_valid && held_alarm |-> cls_alarm)

  // a normal reading always reports the line normal
  `AZS_ASSERT(a_normal_held, out_valid && cls_normal |-> held_normal)

endmodule

bind alarm_zone_supervisor_core azs_checker u_azs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_line_index   (in_line_index),
  .in_sample       (in_sample),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_line_class  (out_line_class),
  .out_held_class  (out_held_class),
  .out_panel_alarm (out_panel_alarm)
);

FILE: tb/sv/alarm_zone_supervisor_core_tb.sv
`timescale 1ns / 1ps
module alarm_zone_supervisor_core_tb;

  localparam int NUM_LINES = azs_pkg::NUM_LINES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [azs_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef enum int {PROF_ALARM, PROF_UNUSED, PROF_NORMAL, PROF_MIXED} line_profile_t;

  typedef struct packed {
    logic [azs_pkg::LINE_W-1:0]   line;
    logic [azs_pkg::SAMPLE_W-1:0] sample;
  } sample_req_t;

  typedef struct packed {
    azs_pkg::cls_t line_class;
    azs_pkg::cls_t held_class;
    logic          panel_alarm;
  } zone_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [azs_pkg::LINE_W-1:0] in_line_index = '0;
  logic [azs_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [azs_pkg::CLS_W-1:0] out_line_class;
  logic [azs_pkg::CLS_W-1:0] out_held_class;
  logic out_panel_alarm;
  logic cfg_wr_en = 1'b0;
  logic [azs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [azs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // zone state as the block should hold it
  logic [azs_pkg::THR_W-1:0] thr_unused = azs_pkg::UNUSED_THR_RST;
  logic [azs_pkg::THR_W-1:0] thr_alarm = azs_pkg::ALARM_THR_RST;
  logic [azs_pkg::CNT_W-1:0] confirm_need = azs_pkg::CONFIRM_CNT_RST;
  logic run_active [NUM_LINES];
  logic [azs_pkg::CNT_W-1:0] run_len [NUM_LINES];
  azs_pkg::cls_t held_state [NUM_LINES];
  logic panel_latched = 1'b0;

  sample_req_t pending_reqs [$];
  zone_status_t due_status [$];
  line_profile_t line_profile [NUM_LINES];

  int send_idle_pct = 14;
  int recv_stall_pct = 70;
  int hold_off_left = 0;
  int errors = 0;
  int n_sent = 0;
  int n_cfg_writes = 0;
  int n_latched = 0;
  int n_panel = 0;
  int cls_seen [3] = '{0, 0, 0};
  int cycle_count = 0;
  sample_req_t next_req;
  zone_status_t want;

  alarm_zone_supervisor_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_line_index  (in_line_index),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_class (out_line_class),
    .out_held_class (out_held_class),
    .out_panel_alarm(out_panel_alarm),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < NUM_LINES; i++) begin
      run_active[i] = 1'b0;
      run_len[i] = '0;
      held_state[i] = azs_pkg::CLS_NORMAL;
      line_profile[i] = PROF_MIXED;
    end
  end

  function automatic zone_status_t update_zone(input logic [azs_pkg::LINE_W-1:0] line,
                                               input logic [azs_pkg::SAMPLE_W-1:0] sample);
    zone_status_t st;
    int run;
    if (sample > thr_unused) st.line_class = azs_pkg::CLS_UNUSED;
    else if (sample < thr_alarm) st.line_class = azs_pkg::CLS_ALARM;
    else st.line_class = azs_pkg::CLS_NORMAL;
    st.held_class = azs_pkg::CLS_NORMAL;
    if (int'(line) < NUM_LINES) begin
      if (line == '0) panel_latched = 1'b0;
      case (st.line_class)
        azs_pkg::CLS_UNUSED: held_state[line] = azs_pkg::CLS_UNUSED;
        azs_pkg::CLS_ALARM: begin
          if (!run_active[line]) begin
            run_active[line] = 1'b1;
            run_len[line] = 3'd1;
          end else begin
            run = int'(run_len[line]) + 1;
            if (run >= int'(confirm_need)) begin
              run = int'(confirm_need);
              held_state[line] = azs_pkg::CLS_ALARM;
              panel_latched = 1'b1;
            end
            run_len[line] = run[azs_pkg::CNT_W-1:0];
          end
        end
        default: begin
          run_active[line] = 1'b0;
          run_len[line] = '0;
          held_state[line] = azs_pkg::CLS_NORMAL;
        end
      endcase
      st.held_class = held_state[line];
    end
    st.panel_alarm = panel_latched;
    return st;
  endfunction

  function automatic logic [azs_pkg::SAMPLE_W-1:0] pick_sample(input line_profile_t prof);
    int roll;
    int lo;
    int hi;
    azs_pkg::cls_t goal;
    roll = int'($urandom_range(99, 0));
    if (roll < 8) return azs_pkg::SAMPLE_W'($urandom_range(4095, 0));
    if (roll < 14) begin
      lo = ($urandom_range(1, 0) != 0) ? int'(thr_alarm) : int'(thr_unused);
      lo = lo + int'($urandom_range(2, 0)) - 1;
      if (lo < 0) lo = 0;
      if (lo > 4095) lo = 4095;
      return azs_pkg::SAMPLE_W'(lo);
    end
    roll = int'($urandom_range(99, 0));
    case (prof)
      PROF_ALARM:  goal = roll < 80 ? azs_pkg::CLS_ALARM :
                          (roll < 90 ? azs_pkg::CLS_UNUSED : azs_pkg::CLS_NORMAL);
      PROF_UNUSED: goal = roll < 70 ? azs_pkg::CLS_UNUSED :
                          (roll < 85 ? azs_pkg::CLS_ALARM : azs_pkg::CLS_NORMAL);
      PROF_NORMAL: goal = roll < 80 ? azs_pkg::CLS_NORMAL :
                          (roll < 90 ? azs_pkg::CLS_ALARM : azs_pkg::CLS_UNUSED);
      default:     goal = roll < 34 ? azs_pkg::CLS_ALARM :
                          (roll < 67 ? azs_pkg::CLS_UNUSED : azs_pkg::CLS_NORMAL);
    endcase
    case (goal)
      azs_pkg::CLS_ALARM: begin
        lo = 0;
        hi = int'(thr_alarm) - 1;
        if (hi > int'(thr_unused)) hi = int'(thr_unused);
      end
      azs_pkg::CLS_UNUSED: begin
        lo = int'(thr_unused) + 1;
        hi = 4095;
      end
      default: begin
        lo = int'(thr_alarm);
        hi = int'(thr_unused);
      end
    endcase
    if (lo > hi) return azs_pkg::SAMPLE_W'($urandom_range(4095, 0));
    return azs_pkg::SAMPLE_W'($urandom_range(hi, lo));
  endfunction

  task automatic push_req(input int line, input int sample);
    sample_req_t r;
    r.line = azs_pkg::LINE_W'(line);
    r.sample = azs_pkg::SAMPLE_W'(sample);
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(input logic [azs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [azs_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    n_cfg_writes++;
    case (idx)
      azs_pkg::CFG_UNUSED_THR:  thr_unused = data;
      azs_pkg::CFG_ALARM_THR:   thr_alarm = data;
      azs_pkg::CFG_CONFIRM_CNT: confirm_need = data[azs_pkg::CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || due_status.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int unused_thr, input int alarm_thr, input int confirm,
                           input int send_pct, input int recv_pct, input int n_items,
                           input int hold);
    int made;
    int k;
    write_reg(azs_pkg::CFG_UNUSED_THR, azs_pkg::CFG_DATA_W'(unused_thr));
    write_reg(azs_pkg::CFG_ALARM_THR, azs_pkg::CFG_DATA_W'(alarm_thr));
    write_reg(azs_pkg::CFG_CONFIRM_CNT, azs_pkg::CFG_DATA_W'(confirm));
    finish_writes();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < NUM_LINES; i++) line_profile[i] = line_profile_t'($urandom_range(3, 0));
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(99, 0) < 85) begin
        // one scan, lines in order, a few skipped
        for (int l = 0; l < NUM_LINES && made < n_items; l++) begin
          if ($urandom_range(9, 0) != 0) begin
            push_req(l, int'(pick_sample(line_profile[l])));
            made++;
          end
        end
      end else begin
        k = int'($urandom_range(4, 1));
        for (int j = 0; j < k && made < n_items; j++) begin
          push_req(int'($urandom_range(15, 0)), int'($urandom_range(4095, 0)));
          made++;
        end
      end
    end
    hold_off_left = hold;
    wait_drained();
  endtask

  task automatic check_field(input string name, input logic [azs_pkg::CLS_W-1:0] exp_val,
                             input logic [azs_pkg::CLS_W-1:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_status.push_back(update_zone(in_line_index, in_sample));
        n_sent++;
      end
      if (in_valid && in_stall) begin
      end else if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_line_index <= next_req.line;
        in_sample <= next_req.sample;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_status.size() == 0) begin
          $display("%0t: unexpected result, expected none, got class %0d held %0d panel %0d",
                   $time, out_line_class, out_held_class, out_panel_alarm);
          errors++;
        end else begin
          want = due_status.pop_front();
          check_field("line_class", want.line_class, out_line_class);
          check_field("held_class", want.held_class, out_held_class);
          check_field("panel_alarm", {1'b0, want.panel_alarm}, {1'b0, out_panel_alarm});
          if (out_line_class < 3) cls_seen[out_line_class]++;
          if (out_held_class == azs_pkg::CLS_ALARM) n_latched++;
          if (out_panel_alarm) n_panel++;
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, due_status.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset thresholds: edges, a run that latches, interruption by unused, new scan
    push_req(0, 0);
    push_req(15, 4095);
    push_req(5, 999);
    push_req(5, 998);
    push_req(5, 0);
    push_req(5, 500);
    push_req(5, 1);
    push_req(5, 3201);
    push_req(5, 10);
    push_req(7, 1000);
    push_req(7, 3200);
    push_req(0, 2000);
    push_req(5, 1000);
    push_req(5, 0);
    push_req(10, 2730);
    push_req(5, 1365);
    wait_drained();

    // unmapped index is ignored, upper data bits of the count are dropped
    write_reg(CFG_UNMAPPED, 12'hABC);
    write_reg(azs_pkg::CFG_CONFIRM_CNT, 12'hFF9);
    finish_writes();
    push_req(3, 0);
    push_req(3, 0);
    push_req(3, 999);
    wait_drained();

    // zero confirm count
    write_reg(azs_pkg::CFG_CONFIRM_CNT, 12'h000);
    finish_writes();
    push_req(4, 0);
    push_req(4, 0);
    push_req(4, 5);
    push_req(0, 3500);
    wait_drained();

    run_phase(3200, 1000, 5, 14, 70, 300, 150);
    run_phase(4095, 0, 7, 14, 70, 150, 0);
    run_phase(0, 4095, 1, 70, 14, 150, 0);
    run_phase(2800, 1500, 2, 70, 14, 300, 120);
    run_phase(int'($urandom_range(4095, 1500)), int'($urandom_range(2000, 0)), 3,
              70, 14, 250, 0);
    run_phase(int'($urandom_range(4095, 0)), int'($urandom_range(4095, 0)),
              int'($urandom_range(7, 1)), 0, 0, 200, 0);
    run_phase(int'($urandom_range(4095, 2000)), int'($urandom_range(1800, 100)),
              int'($urandom_range(7, 1)), 0, 0, 350, 0);
    run_phase(3200, 1000, 7, 0, 0, 300, 0);

    $display("covered %0d requests across %0d register writes and eight threshold settings",
             n_sent, n_cfg_writes);
    $display("results: %0d alarm, %0d unused, %0d normal; %0d latched alarm, %0d panel alarm",
             cls_seen[azs_pkg::CLS_ALARM], cls_seen[azs_pkg::CLS_UNUSED],
             cls_seen[azs_pkg::CLS_NORMAL], n_latched, n_panel);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/azs_pkg.sv
hdl/azs_classify.sv
hdl/azs_line_state.sv
hdl/alarm_zone_supervisor_core.sv
hdl/azs_checker.sv
tb/sv/alarm_zone_supervisor_core_tb.sv
